### design/art_pkg.sv
// address region table: shared types, widths and codes
// used by art_mem, art_cmp, art_ctrl and the address_region_table top level
`default_nettype none

package art_pkg;

    localparam int MAX_REGIONS = 64;
    localparam int ADDR_W      = 32;
    localparam int PAGE_SHIFT  = 12;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int FLAG_W      = 3;
    localparam int CODE_W      = 2;
    localparam int COUNT_W     = 7;
    localparam int FAULT_W     = 32;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_REGIONS);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_FAULT  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_WRITE_DENIED = 3'd2,
        ST_READ_PRESENT = 3'd3,
        ST_READ_DENIED  = 3'd4,
        ST_OVERLAP      = 3'd5,
        ST_BAD_RANGE    = 3'd6,
        ST_FULL         = 3'd7
    } t_status;

    // fault code bits
    localparam int FC_WRITE = 1;
    localparam logic [CODE_W-1:0] FC_READ_PRESENT = 2'd1;

    // flag bits
    localparam int FL_READ  = 0;
    localparam int FL_WRITE = 1;
    localparam int FL_EXEC  = 2;

    typedef struct packed {
        logic [ADDR_W-1:0] base_addr;
        logic [ADDR_W-1:0] lim_addr;
        logic [FLAG_W-1:0] perm;
    } t_region;

    typedef struct packed {
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] end_addr;
        logic [FLAG_W-1:0] new_flags;
        logic [ADDR_W-1:0] lookup_addr;
        logic [CODE_W-1:0] fault_code;
    } t_req;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_region          data;
    } t_mem_wr;

    typedef struct packed {
        logic ge_base;   // x >= base
        logic lt_lim;    // x < limit
        logic e_above;   // end operand > base
    } t_cmp;

    typedef struct packed {
        t_status            status;
        logic               found;
        logic [ADDR_W-1:0]  region_start;
        logic [ADDR_W-1:0]  region_end;
        logic [FLAG_W-1:0]  region_flags;
        logic [ADDR_W-1:0]  page_base;
        logic               grant_write;
        logic [COUNT_W-1:0] region_count;
        logic [FAULT_W-1:0] fault_total;
    } t_result;

endpackage

`default_nettype wire

### design/art_mem.sv
// region store: one write port, one read port with registered read data
// depends on art_pkg for the entry type and depth
`default_nettype none

module art_mem (
    input  wire logic             i_clk,
    input  wire art_pkg::t_mem_wr i_wr,
    input  wire art_pkg::t_mem_rd i_rd,
    output art_pkg::t_region      o_q
);
    import art_pkg::*;

    t_region r_mem [MAX_REGIONS];
    t_region r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_q <= r_mem[i_rd.addr];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

### design/art_cmp.sv
// shared address compare unit, used for range checks, lookup and insert scan
// depends on art_pkg
`default_nettype none

module art_cmp (
    input  wire logic [art_pkg::ADDR_W-1:0] i_x,
    input  wire logic [art_pkg::ADDR_W-1:0] i_e,
    input  wire art_pkg::t_region           i_ent,
    output art_pkg::t_cmp                   o_cmp
);
    import art_pkg::*;

    assign o_cmp.ge_base = (i_x >= i_ent.base_addr);
    assign o_cmp.lt_lim  = (i_x <  i_ent.lim_addr);
    assign o_cmp.e_above = (i_e >  i_ent.base_addr);

endmodule

`default_nettype wire

### design/art_ctrl.sv
// sequencer: insert scan and shift, lookup walk, recent-region cache, counters
// depends on art_pkg; drives art_mem and art_cmp
`default_nettype none

module art_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire art_pkg::t_cmd              i_cmd,
    input  wire art_pkg::t_req              i_req,
    output logic                            o_ready,
    output logic                            o_done,
    input  wire logic                       i_res_rdy,
    output art_pkg::t_result                o_res,
    output art_pkg::t_mem_rd                o_mem_rd,
    output art_pkg::t_mem_wr                o_mem_wr,
    input  wire art_pkg::t_region           i_mem_q,
    output logic [art_pkg::ADDR_W-1:0]      o_cmp_x,
    output logic [art_pkg::ADDR_W-1:0]      o_cmp_e,
    output art_pkg::t_region                o_cmp_ent,
    input  wire art_pkg::t_cmp              i_cmp
);
    import art_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    t_req               r_req;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    logic [CNT_W-1:0]   r_pos;
    logic               r_prev_ovl;
    logic [CNT_W-1:0]   r_count;
    logic [FAULT_W-1:0] r_faults;
    logic               r_cache_vld;
    t_region            r_cache;
    t_result            r_res;

    logic scan_issue;
    logic shift_issue;
    logic hit;

    function automatic t_result fn_code(input t_status st);
        t_result res;
        res        = '0;
        res.status = st;
        return res;
    endfunction

    function automatic t_result fn_hit(input t_cmd cmd, input logic [CODE_W-1:0] code,
                                       input logic [ADDR_W-1:0] addr, input t_region ent);
        t_result res;
        t_status st;
        res = '0;
        st  = ST_OK;
        if (cmd == CMD_FAULT) begin
            if (code[FC_WRITE]) begin
                if (!ent.perm[FL_WRITE]) begin
                    st = ST_WRITE_DENIED;
                end
            end else if (code == FC_READ_PRESENT) begin
                st = ST_READ_PRESENT;
            end else if (!(ent.perm[FL_READ] || ent.perm[FL_EXEC])) begin
                st = ST_READ_DENIED;
            end
            if (st == ST_OK) begin
                res.page_base   = addr & ~PAGE_MASK;
                res.grant_write = ent.perm[FL_WRITE];
            end
        end
        res.status       = st;
        res.found        = 1'b1;
        res.region_start = ent.base_addr;
        res.region_end   = ent.lim_addr;
        res.region_flags = ent.perm;
        return res;
    endfunction

    assign hit         = i_cmp.ge_base && i_cmp.lt_lim;
    assign scan_issue  = (r_state == S_SCAN) && (r_idx < r_count);
    assign shift_issue = (r_state == S_SHIFT) && (r_idx > r_pos);
    assign o_ready     = (r_state == S_IDLE);
    assign o_done      = (r_state == S_DONE);

    always_comb begin
        o_cmp_x = (r_cmd == CMD_INSERT) ? r_req.start_addr : r_req.lookup_addr;
        o_cmp_e = r_req.end_addr;
        if (r_state == S_START) begin
            if (r_cmd == CMD_INSERT) begin
                // start >= end check goes through the same compare
                o_cmp_ent = '{base_addr: r_req.end_addr, lim_addr: '0, perm: '0};
            end else begin
                o_cmp_ent = r_cache;
            end
        end else begin
            o_cmp_ent = i_mem_q;
        end
    end

    always_comb begin
        o_mem_rd.en   = scan_issue || shift_issue;
        o_mem_rd.addr = scan_issue ? r_idx[IDX_W-1:0] : IDX_W'(r_idx - CNT_W'(1));
        o_mem_wr      = '0;
        if (r_state == S_SHIFT) begin
            if (r_pend) begin
                o_mem_wr.en   = 1'b1;
                o_mem_wr.addr = r_pidx + IDX_W'(1);
                o_mem_wr.data = i_mem_q;
            end else if (r_idx == r_pos) begin
                o_mem_wr.en   = 1'b1;
                o_mem_wr.addr = r_pos[IDX_W-1:0];
                o_mem_wr.data = '{base_addr: r_req.start_addr, lim_addr: r_req.end_addr,
                                  perm: r_req.new_flags};
            end
        end
    end

    always_comb begin
        o_res              = r_res;
        o_res.region_count = COUNT_W'(r_count);
        o_res.fault_total  = r_faults;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_faults    <= '0;
            r_cache_vld <= 1'b0;
            r_cache     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_req   <= i_req;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_idx      <= '0;
                    r_pend     <= 1'b0;
                    r_prev_ovl <= 1'b0;
                    case (r_cmd)
                        CMD_CLEAR: begin
                            r_count     <= '0;
                            r_cache_vld <= 1'b0;
                            r_cache     <= '0;
                            r_res       <= fn_code(ST_OK);
                            r_state     <= S_DONE;
                        end
                        CMD_INSERT: begin
                            if (i_cmp.ge_base) begin
                                r_res   <= fn_code(ST_BAD_RANGE);
                                r_state <= S_DONE;
                            end else if (r_count == CNT_MAX) begin
                                r_res   <= fn_code(ST_FULL);
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        default: begin
                            if (r_cmd == CMD_FAULT) begin
                                r_faults <= r_faults + FAULT_W'(1);
                            end
                            if (r_cache_vld && hit) begin
                                r_res   <= fn_hit(r_cmd, r_req.fault_code,
                                                  r_req.lookup_addr, r_cache);
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    r_idx  <= r_idx + CNT_W'(scan_issue);
                    r_pend <= scan_issue;
                    r_pidx <= r_idx[IDX_W-1:0];
                    if (r_cmd == CMD_INSERT) begin
                        if (r_pend && !i_cmp.ge_base) begin
                            // first entry starting above the new start
                            if (r_prev_ovl || i_cmp.e_above) begin
                                r_res   <= fn_code(ST_OVERLAP);
                                r_state <= S_DONE;
                            end else begin
                                r_pos   <= CNT_W'(r_pidx);
                                r_idx   <= r_count;
                                r_pend  <= 1'b0;
                                r_state <= S_SHIFT;
                            end
                        end else if (r_pend) begin
                            r_prev_ovl <= i_cmp.lt_lim;
                        end else if (!scan_issue) begin
                            if (r_prev_ovl) begin
                                r_res   <= fn_code(ST_OVERLAP);
                                r_state <= S_DONE;
                            end else begin
                                r_pos   <= r_count;
                                r_idx   <= r_count;
                                r_state <= S_SHIFT;
                            end
                        end
                    end else begin
                        if (r_pend && hit) begin
                            r_cache_vld <= 1'b1;
                            r_cache     <= i_mem_q;
                            r_res       <= fn_hit(r_cmd, r_req.fault_code,
                                                  r_req.lookup_addr, i_mem_q);
                            r_state     <= S_DONE;
                        end else if (!r_pend && !scan_issue) begin
                            r_res   <= fn_code(ST_NOT_FOUND);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    r_pend <= shift_issue;
                    if (shift_issue) begin
                        r_idx  <= r_idx - CNT_W'(1);
                        r_pidx <= IDX_W'(r_idx - CNT_W'(1));
                    end
                    if (!r_pend && (r_idx == r_pos)) begin
                        r_count <= r_count + CNT_W'(1);
                        r_res   <= fn_code(ST_OK);
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_pend <= 1'b0;
                    if (i_res_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/address_region_table.sv
// Address region table: keeps up to 64 sorted, non-overlapping regions and a one-entry cache
// of the last region hit, and answers one result per command. Commands run one at a time:
// a find or fault check is answered from the cache on a hit; otherwise the table is walked,
// one entry per cycle through the single read port of the region
// store; an insert walks the table to find its place and then moves every later entry up
// one slot; clear empties the table and the cache. A finished result waits in the output
// register, which frees the sequencer to return to idle.
// Depends on art_pkg, art_mem, art_cmp and art_ctrl.
`default_nettype none

module address_region_table (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // start_addr[31:0], end_addr[63:32], new_flags[66:64], lookup_addr[98:67],
    // fault_code[100:99], zero[103:101]
    input  wire logic [103:0] i_s_tdata,
    // command[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // region_start[31:0], region_end[63:32], region_flags[66:64], page_base[98:67],
    // grant_write[99], region_count[106:100], fault_total[138:107], zero[143:139]
    output logic [143:0]      o_m_tdata,
    // status[2:0], found[3]
    output logic [3:0]        o_m_tuser
);
    import art_pkg::*;

    t_req      req;
    t_cmd      cmd;
    t_mem_rd   mem_rd;
    t_mem_wr   mem_wr;
    t_region   mem_q;
    logic [ADDR_W-1:0] cmp_x;
    logic [ADDR_W-1:0] cmp_e;
    t_region   cmp_ent;
    t_cmp      cmp_res;
    logic      ctrl_ready;
    logic      ctrl_done;
    logic      res_rdy;
    t_result   ctrl_res;
    logic      in_xfer;

    logic      r_out_vld;
    t_result   r_out;

    assign req.start_addr  = i_s_tdata[31:0];
    assign req.end_addr    = i_s_tdata[63:32];
    assign req.new_flags   = i_s_tdata[66:64];
    assign req.lookup_addr = i_s_tdata[98:67];
    assign req.fault_code  = i_s_tdata[100:99];
    assign cmd             = t_cmd'(i_s_tuser);

    assign o_s_tready = ctrl_ready;
    assign in_xfer    = i_s_tvalid && ctrl_ready;
    assign res_rdy    = !r_out_vld || i_m_tready;

    art_mem u_mem (
        .i_clk (i_clk),
        .i_wr  (mem_wr),
        .i_rd  (mem_rd),
        .o_q   (mem_q)
    );

    art_cmp u_cmp (
        .i_x   (cmp_x),
        .i_e   (cmp_e),
        .i_ent (cmp_ent),
        .o_cmp (cmp_res)
    );

    art_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_xfer),
        .i_cmd     (cmd),
        .i_req     (req),
        .o_ready   (ctrl_ready),
        .o_done    (ctrl_done),
        .i_res_rdy (res_rdy),
        .o_res     (ctrl_res),
        .o_mem_rd  (mem_rd),
        .o_mem_wr  (mem_wr),
        .i_mem_q   (mem_q),
        .o_cmp_x   (cmp_x),
        .o_cmp_e   (cmp_e),
        .o_cmp_ent (cmp_ent),
        .i_cmp     (cmp_res)
    );

    // output register between the sequencer and the result stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ctrl_done && res_rdy) begin
            r_out_vld <= 1'b1;
            r_out     <= ctrl_res;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = {r_out.found, r_out.status};
    assign o_m_tdata  = {5'd0, r_out.fault_total, r_out.region_count, r_out.grant_write,
                         r_out.page_base, r_out.region_flags, r_out.region_end,
                         r_out.region_start};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.region_count <= COUNT_W'(MAX_REGIONS)))
        else $error("region count beyond table depth");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !o_s_tready)
        else $error("input taken while an item is in progress");

    a_idle_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ctrl_ready && ctrl_done))
        else $error("sequencer idle and done together");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.found) |->
            (r_out.region_start == '0 && r_out.region_end == '0 && r_out.page_base == '0))
        else $error("region fields set without a hit");
`endif

endmodule

`default_nettype wire
